/* design/npec_pkg.sv */
// Package: widths, register indexes and item types for the near-plane clipper.
package npec_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned MarginW = 31;
  localparam int unsigned MagW = 33;   // |q - p| fits in 33 bits
  localparam int unsigned DzW = 32;    // 0 < dist <= dz < 2^32
  localparam int unsigned ProdW = MagW + DzW;
  localparam int unsigned QuoW = MagW; // quotient never exceeds the magnitude
  localparam int unsigned NumCells = QuoW;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [MarginW-1:0] NearMarginReset = MarginW'(6554);

  typedef enum logic [CfgIdxW-1:0] {
    REG_CAMERA_DEPTH = 1'b0,
    REG_NEAR_MARGIN  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] start_z;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] end_z;
  } seg_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] clip_start_x;
    logic signed [CoordW-1:0] clip_start_y;
    logic signed [CoordW-1:0] clip_start_z;
    logic signed [CoordW-1:0] clip_end_x;
    logic signed [CoordW-1:0] clip_end_y;
    logic signed [CoordW-1:0] clip_end_z;
  } seg_out_t;

  // Data carried along the divider chain
  typedef struct packed {
    logic                     keep;     // segment gives a result
    logic                     clip_s;   // start endpoint moved
    logic                     clip_e;   // end endpoint moved
    logic signed [CoordW-1:0] base_x;   // endpoint being moved
    logic signed [CoordW-1:0] base_y;
    logic signed [CoordW-1:0] plane;
    logic                     neg_x;
    logic                     neg_y;
    logic [DzW-1:0]           dz;
    logic [ProdW-1:0]         rem_x;    // partial remainder, reduced by the shifted divisor per cell
    logic [ProdW-1:0]         rem_y;
    logic [QuoW-1:0]          quo_x;
    logic [QuoW-1:0]          quo_y;
    seg_out_t                 pass;     // unchanged segment
  } div_lane_t;

endpackage

/* design/npec_if.sv */
// Interfaces: valid/ready item channel and configuration write channel.
interface npec_stream_if #(parameter int unsigned Width = 32);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface npec_cfg_if #(parameter int unsigned IdxW = 1, parameter int unsigned DataW = 32);
  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  index;
  logic [DataW-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

/* design/npec_prep.sv */
// Front stage: plane depth, endpoint test, products for the divider chain.
module npec_prep (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  npec_pkg::seg_in_t               seg_i,
  input  logic signed [npec_pkg::CoordW-1:0] camera_depth_i,
  input  logic [npec_pkg::MarginW-1:0]    near_margin_i,
  output npec_pkg::div_lane_t             lane_o
);
  import npec_pkg::*;

  logic signed [CoordW+1:0] plane_w;
  logic signed [CoordW-1:0] plane;
  logic                     front_s, front_e;
  logic signed [CoordW-1:0] p_x, p_y, q_x, q_y, p_z, q_z;
  logic signed [CoordW:0]   dlt_x, dlt_y, gap_w, dz_w;
  logic [MagW-1:0]          mag_x, mag_y;
  logic [DzW-1:0]           gap, dz;
  div_lane_t                lane_d, lane_q;

  assign plane_w = (CoordW+2)'(camera_depth_i) + $signed({3'b000, near_margin_i});
  assign plane = (plane_w > (CoordW+2)'(32'sh7fffffff)) ? 32'sh7fffffff
                                                        : plane_w[CoordW-1:0];
  assign front_s = seg_i.start_z < plane;
  assign front_e = seg_i.end_z < plane;

  always_comb begin
    if (front_s) begin
      p_x = seg_i.start_x; p_y = seg_i.start_y; p_z = seg_i.start_z;
      q_x = seg_i.end_x;   q_y = seg_i.end_y;   q_z = seg_i.end_z;
    end else begin
      p_x = seg_i.end_x;   p_y = seg_i.end_y;   p_z = seg_i.end_z;
      q_x = seg_i.start_x; q_y = seg_i.start_y; q_z = seg_i.start_z;
    end
    dlt_x  = (CoordW+1)'(q_x) - (CoordW+1)'(p_x);
    dlt_y  = (CoordW+1)'(q_y) - (CoordW+1)'(p_y);
    gap_w  = (CoordW+1)'(plane) - (CoordW+1)'(p_z);
    dz_w   = (CoordW+1)'(q_z) - (CoordW+1)'(p_z);
    mag_x  = dlt_x[CoordW] ? MagW'(-dlt_x) : MagW'(dlt_x);
    mag_y  = dlt_y[CoordW] ? MagW'(-dlt_y) : MagW'(dlt_y);
    gap    = gap_w[DzW-1:0];
    dz     = dz_w[DzW-1:0];

    lane_d        = '0;
    lane_d.keep   = !(front_s && front_e);
    lane_d.clip_s = front_s && !front_e;
    lane_d.clip_e = front_e && !front_s;
    lane_d.base_x = p_x;
    lane_d.base_y = p_y;
    lane_d.plane  = plane;
    lane_d.neg_x  = dlt_x[CoordW];
    lane_d.neg_y  = dlt_y[CoordW];
    lane_d.dz     = dz;
    // one 33x32 multiply per lane, registered with the rest of the item
    lane_d.rem_x  = ProdW'(mag_x) * ProdW'(gap);
    lane_d.rem_y  = ProdW'(mag_y) * ProdW'(gap);
    lane_d.pass   = {seg_i.start_x, seg_i.start_y, seg_i.start_z,
                     seg_i.end_x, seg_i.end_y, seg_i.end_z};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;
endmodule

/* design/npec_div_cell.sv */
// Divider cell: one restoring quotient bit for the x and y lanes.
module npec_div_cell #(
  parameter int unsigned Bit = 0
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  npec_pkg::div_lane_t lane_i,
  output npec_pkg::div_lane_t lane_o
);
  import npec_pkg::*;

  localparam int unsigned Sh = Bit;

  logic [ProdW:0]   trial_x, trial_y;
  logic [ProdW:0]   dv;
  div_lane_t        lane_d, lane_q;

  always_comb begin
    dv = (ProdW+1)'(lane_i.dz) << Sh;
    trial_x = (ProdW+1)'(lane_i.rem_x) - dv;
    trial_y = (ProdW+1)'(lane_i.rem_y) - dv;
    lane_d = lane_i;
    if (!trial_x[ProdW]) begin
      lane_d.rem_x = trial_x[ProdW-1:0];
      lane_d.quo_x[Bit] = 1'b1;
    end
    if (!trial_y[ProdW]) begin
      lane_d.rem_y = trial_y[ProdW-1:0];
      lane_d.quo_y[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;
endmodule

/* design/near_plane_edge_clipper.sv */
// Top level: near-plane segment clipper with a bit-per-cell divider chain.
//
//  channel   dir  payload                        handshake
//  seg_in    in   start_x/y/z, end_x/y/z         valid & ready
//  seg_out   out  clip_start_x/y/z, clip_end_x/y/z valid & ready
//  cfg       in   index, wdata (camera, margin)  valid & ready, always ready
//
// One item per cycle while the output is not stalled; the pipeline is one product stage,
// one cell per quotient bit of the 33-cell divider chain, and one output register.
// The whole pipeline advances together and holds while a result waits on a
// stalled output. Reset clears the valid bits and loads the register defaults.
module near_plane_edge_clipper (
  input  logic clk_i,
  input  logic rst_ni,
  npec_stream_if.sink   seg_in,
  npec_stream_if.source seg_out,
  npec_cfg_if.sink      cfg
);
  import npec_pkg::*;

  localparam int unsigned Stages = NumCells + 1;

  logic signed [CoordW-1:0] camera_depth_q;
  logic [MarginW-1:0]       near_margin_q;
  logic [Stages-1:0]        vld_q;
  logic                     adv;
  logic                     out_vld_q;
  seg_out_t                 out_q, out_d;
  div_lane_t                lanes [NumCells+1];
  seg_in_t                  seg;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      camera_depth_q <= '0;
      near_margin_q  <= NearMarginReset;
    end else if (cfg.valid) begin
      unique case (cfg_reg_e'(cfg.index))
        REG_CAMERA_DEPTH: camera_depth_q <= cfg.wdata;
        REG_NEAR_MARGIN:  near_margin_q  <= cfg.wdata[MarginW-1:0];
        default: ;
      endcase
    end
  end

  // Advance when the output slot is free or being drained
  assign adv = !out_vld_q || seg_out.ready;
  assign seg_in.ready = adv;
  assign seg = seg_in_t'(seg_in.data);

  npec_prep u_prep (
    .clk_i, .en_i(adv), .seg_i(seg),
    .camera_depth_i(camera_depth_q), .near_margin_i(near_margin_q),
    .lane_o(lanes[0])
  );

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    npec_div_cell #(.Bit(NumCells-1-g)) u_cell (
      .clk_i, .en_i(adv), .lane_i(lanes[g]), .lane_o(lanes[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Stages-2:0], seg_in.valid};
  end

  always_comb begin
    logic signed [CoordW-1:0] nx, ny;
    div_lane_t l;
    l = lanes[NumCells];
    nx = l.neg_x ? l.base_x - CoordW'(l.quo_x) : l.base_x + CoordW'(l.quo_x);
    ny = l.neg_y ? l.base_y - CoordW'(l.quo_y) : l.base_y + CoordW'(l.quo_y);
    out_d = l.pass;
    if (l.clip_s) begin
      out_d.clip_start_x = nx; out_d.clip_start_y = ny; out_d.clip_start_z = l.plane;
    end
    if (l.clip_e) begin
      out_d.clip_end_x = nx; out_d.clip_end_y = ny; out_d.clip_end_z = l.plane;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= vld_q[Stages-1] && lanes[NumCells].keep;
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  assign seg_out.valid = out_vld_q;
  assign seg_out.data  = out_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !seg_out.ready |=> out_vld_q && $stable(out_q)) else $error("result lost");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> seg_in.ready) else $error("stall without result");
  a_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !vld_q[Stages-1] |=> !out_vld_q) else $error("invented result");
`endif
endmodule
